@@ hw/rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned TagBitsDefault    = 16;

  localparam int unsigned SevW    = 16;
  localparam int unsigned ArrW    = 32;
  localparam int unsigned TagPortW = 16;
  localparam int unsigned StatusW = 3;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdServe  = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;

  localparam logic [StatusW-1:0] StInserted = 3'd0;
  localparam logic [StatusW-1:0] StServed   = 3'd1;
  localparam logic [StatusW-1:0] StEmpty    = 3'd2;
  localparam logic [StatusW-1:0] StFull     = 3'd3;
  localparam logic [StatusW-1:0] StCleared  = 3'd4;

  typedef struct packed {
    logic insert;
    logic serve;
    logic clear;
  } cell_ctl_t;

endpackage

@@ hw/rtl/severity_priority_queue.sv @@
// bounded max-priority queue built as a sorted row of cells
// command channel: cmd_i, severity_i and tag_i are taken when start is high
// and busy is low; busy is always low, so a command may be issued every cycle
// result channel: valid_o pulses for one cycle with status_o, served_tag_o
// and served_severity_o; the receiver cannot stall, so nothing waits
// latency: the result appears in the cycle after the command is taken
// throughput: one command per cycle, set by the single compare and shift step
// that every cell does on each insert or serve
// cell 0 always holds the next item to be served; an insert is compared with
// every cell at once and the lower-ranked cells shift down one place; a serve
// shifts all cells up one place
// an insert into a full queue is dropped and flagged; a serve on an empty
// queue is flagged; clear empties the queue and restarts the arrival count
// command code 3 is ignored and gives no result
// reset empties the queue, zeroes the arrival count and drops any result
module severity_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned TAG_BITS    = TagBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd_i,
  input  logic [SevW-1:0]     severity_i,
  input  logic [TagPortW-1:0] tag_i,
  output logic                valid_o,
  output logic [StatusW-1:0]  status_o,
  output logic [TagPortW-1:0] served_tag_o,
  output logic [SevW-1:0]     served_severity_o
);

  localparam int unsigned TagW = (TAG_BITS < TagPortW) ? TAG_BITS : TagPortW;

  logic            accept;
  logic            full;
  logic [TagW-1:0] new_tag;
  cell_ctl_t       ctl;

  logic [ArrW-1:0] arr_cnt_q, arr_cnt_d;

  logic                valid_q, valid_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [TagPortW-1:0] stag_q, stag_d;
  logic [SevW-1:0]     ssev_q, ssev_d;

  logic            c_take  [QUEUE_DEPTH];
  logic            c_valid [QUEUE_DEPTH];
  logic [SevW-1:0] c_sev   [QUEUE_DEPTH];
  logic [ArrW-1:0] c_arr   [QUEUE_DEPTH];
  logic [TagW-1:0] c_tag   [QUEUE_DEPTH];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign full    = c_valid[QUEUE_DEPTH-1];
  assign new_tag = tag_i[TagW-1:0];

  assign ctl.insert = accept && (cmd_i == CmdInsert) && !full;
  assign ctl.serve  = accept && (cmd_i == CmdServe) && c_valid[0];
  assign ctl.clear  = accept && (cmd_i == CmdClear);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            p_take;
    logic            p_valid;
    logic [SevW-1:0] p_sev;
    logic [ArrW-1:0] p_arr;
    logic [TagW-1:0] p_tag;
    logic            n_valid;
    logic [SevW-1:0] n_sev;
    logic [ArrW-1:0] n_arr;
    logic [TagW-1:0] n_tag;

    if (i == 0) begin : g_first
      assign p_take  = 1'b0;
      assign p_valid = 1'b0;
      assign p_sev   = '0;
      assign p_arr   = '0;
      assign p_tag   = '0;
    end else begin : g_mid
      assign p_take  = c_take[i-1];
      assign p_valid = c_valid[i-1];
      assign p_sev   = c_sev[i-1];
      assign p_arr   = c_arr[i-1];
      assign p_tag   = c_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_sev   = '0;
      assign n_arr   = '0;
      assign n_tag   = '0;
    end else begin : g_inner
      assign n_valid = c_valid[i+1];
      assign n_sev   = c_sev[i+1];
      assign n_arr   = c_arr[i+1];
      assign n_tag   = c_tag[i+1];
    end

    spq_cell #(
      .TagW(TagW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .new_sev_i   (severity_i),
      .new_arr_i   (arr_cnt_q),
      .new_tag_i   (new_tag),
      .prev_take_i (p_take),
      .prev_valid_i(p_valid),
      .prev_sev_i  (p_sev),
      .prev_arr_i  (p_arr),
      .prev_tag_i  (p_tag),
      .next_valid_i(n_valid),
      .next_sev_i  (n_sev),
      .next_arr_i  (n_arr),
      .next_tag_i  (n_tag),
      .take_o      (c_take[i]),
      .valid_o     (c_valid[i]),
      .sev_o       (c_sev[i]),
      .arr_o       (c_arr[i]),
      .tag_o       (c_tag[i])
    );
  end

  always_comb begin
    arr_cnt_d = arr_cnt_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    stag_d    = '0;
    ssev_d    = '0;
    if (accept) begin
      case (cmd_i)
        CmdInsert: begin
          arr_cnt_d = arr_cnt_q + 1'b1;
          valid_d   = 1'b1;
          status_d  = full ? StFull : StInserted;
        end
        CmdServe: begin
          arr_cnt_d = arr_cnt_q + 1'b1;
          valid_d   = 1'b1;
          if (c_valid[0]) begin
            status_d              = StServed;
            stag_d[TagW-1:0]      = c_tag[0];
            ssev_d                = c_sev[0];
          end else begin
            status_d = StEmpty;
          end
        end
        CmdClear: begin
          arr_cnt_d = '0;
          valid_d   = 1'b1;
          status_d  = StCleared;
        end
        default: begin
          valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arr_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      arr_cnt_q <= arr_cnt_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    stag_q   <= stag_d;
    ssev_q   <= ssev_d;
  end

  assign valid_o           = valid_q;
  assign status_o          = status_q;
  assign served_tag_o      = stag_q;
  assign served_severity_o = ssev_q;

endmodule

@@ hw/rtl/spq_cell.sv @@
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned TagW = TagBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic [SevW-1:0] new_sev_i,
  input  logic [ArrW-1:0] new_arr_i,
  input  logic [TagW-1:0] new_tag_i,
  input  logic            prev_take_i,
  input  logic            prev_valid_i,
  input  logic [SevW-1:0] prev_sev_i,
  input  logic [ArrW-1:0] prev_arr_i,
  input  logic [TagW-1:0] prev_tag_i,
  input  logic            next_valid_i,
  input  logic [SevW-1:0] next_sev_i,
  input  logic [ArrW-1:0] next_arr_i,
  input  logic [TagW-1:0] next_tag_i,
  output logic            take_o,
  output logic            valid_o,
  output logic [SevW-1:0] sev_o,
  output logic [ArrW-1:0] arr_o,
  output logic [TagW-1:0] tag_o
);

  logic            valid_q, valid_d;
  logic [SevW-1:0] sev_q, sev_d;
  logic [ArrW-1:0] arr_q, arr_d;
  logic [TagW-1:0] tag_q, tag_d;
  logic            beats;

  // new item ranks ahead: higher severity, or same severity and earlier arrival
  assign beats  = (new_sev_i > sev_q) || ((new_sev_i == sev_q) && (new_arr_i < arr_q));
  assign take_o = !valid_q || beats;

  always_comb begin
    valid_d = valid_q;
    sev_d   = sev_q;
    arr_d   = arr_q;
    tag_d   = tag_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.serve) begin
      valid_d = next_valid_i;
      sev_d   = next_sev_i;
      arr_d   = next_arr_i;
      tag_d   = next_tag_i;
    end else if (ctl_i.insert && take_o) begin
      if (prev_take_i) begin
        // displaced from above: shift down one place
        valid_d = prev_valid_i;
        sev_d   = prev_sev_i;
        arr_d   = prev_arr_i;
        tag_d   = prev_tag_i;
      end else begin
        valid_d = 1'b1;
        sev_d   = new_sev_i;
        arr_d   = new_arr_i;
        tag_d   = new_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sev_q <= sev_d;
    arr_q <= arr_d;
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign sev_o   = sev_q;
  assign arr_o   = arr_q;
  assign tag_o   = tag_q;

endmodule
